// ----- rtl/core/wspm_pkg.sv -----
// Package with the shared types, register codes and reset values of the screen power manager.
package wspm_pkg;

  localparam int LEVEL_COUNT_DEF = 8;

  localparam logic [15:0] HOLD_TIME_RST  = 16'd1500;
  localparam logic [23:0] DIM_TIME_RST   = 24'd10000;
  localparam logic [23:0] OFF_TIME_RST   = 24'd15000;
  localparam logic [7:0]  DIM_DUTY_RST   = 8'd20;
  localparam logic [7:0]  TORCH_DUTY_RST = 8'd255;
  localparam logic [63:0] TABLE_RST      = 64'd0;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOLD_TIME  = 3'd0,
    CFG_DIM_TIME   = 3'd1,
    CFG_OFF_TIME   = 3'd2,
    CFG_DIM_DUTY   = 3'd3,
    CFG_TORCH_DUTY = 3'd4,
    CFG_TABLE      = 3'd5,
    CFG_ALWAYS_ON  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MODE_UPDATE     = 3'd0,
    MODE_ACTIVITY   = 3'd1,
    MODE_WAKE       = 3'd2,
    MODE_BRIGHTNESS = 3'd3,
    MODE_TAKE_TOUCH = 3'd4,
    MODE_POWER_OFF  = 3'd5
  } mode_e;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_SHORT = 2'd1;
  localparam logic [1:0] EVT_HOLD  = 2'd2;

  typedef struct packed {
    logic [15:0] hold_time;
    logic [23:0] dim_time;
    logic [23:0] off_time;
    logic [7:0]  dim_duty;
    logic [7:0]  torch_duty;
    logic [63:0] level_duties;
    logic        always_on;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] time_ms;
    logic        wrist_raised;
    logic        button_down;
    logic [7:0]  level;
    logic        torch_on;
    logic        by_touch;
  } in_item_t;

  typedef struct packed {
    logic [1:0] button_event;
    logic [7:0] backlight_duty;
    logic       duty_written;
    logic       screen_is_on;
    logic       wake_touch_taken;
    logic       sleep_request;
  } out_item_t;

endpackage

// ----- rtl/core/wearable_screen_power_manager_top.sv -----
// Top level of the screen power manager: input and result registers around the event core.
//
// One event beat is taken per cycle. An accepted event is held in the input register and
// then passes through the single-pass logic into the result register once that register
// is free to take it. The state update is a single pass of compares and selects, so a
// stalled result register is the only thing that slows the input. Configuration writes
// take effect at the next clock edge and must only be made while no beat is in flight.
module wearable_screen_power_manager_top #(
  parameter int LEVEL_COUNT = wspm_pkg::LEVEL_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wspm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wspm_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [wspm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wspm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wspm_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      advance;
  out_item_t result;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  wspm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wspm_core #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("Result beat missing after an event was processed.");
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("Waiting event was dropped or changed.");
  a_sleep_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sleep_request |->
      out_data.backlight_duty == 8'd0 && !out_data.screen_is_on)
    else $error("Power off result with screen or duty still on.");
`endif

endmodule

// ----- rtl/core/wspm_cfg.sv -----
// Configuration register file of the screen power manager.
module wspm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wspm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wspm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output wspm_pkg::cfg_t                 cfg
);
  import wspm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_time    <= HOLD_TIME_RST;
      cfg.dim_time     <= DIM_TIME_RST;
      cfg.off_time     <= OFF_TIME_RST;
      cfg.dim_duty     <= DIM_DUTY_RST;
      cfg.torch_duty   <= TORCH_DUTY_RST;
      cfg.level_duties <= TABLE_RST;
      cfg.always_on    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_TIME:  cfg.hold_time    <= cfg_data[15:0];
        CFG_DIM_TIME:   cfg.dim_time     <= cfg_data[23:0];
        CFG_OFF_TIME:   cfg.off_time     <= cfg_data[23:0];
        CFG_DIM_DUTY:   cfg.dim_duty     <= cfg_data[7:0];
        CFG_TORCH_DUTY: cfg.torch_duty   <= cfg_data[7:0];
        CFG_TABLE:      cfg.level_duties <= cfg_data;
        CFG_ALWAYS_ON:  cfg.always_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/wspm_core.sv -----
// Event state registers and the single-pass next-state and result logic.
module wspm_core #(
  parameter int LEVEL_COUNT = wspm_pkg::LEVEL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  wspm_pkg::in_item_t  item,
  input  wspm_pkg::cfg_t      cfg,
  output wspm_pkg::out_item_t result
);
  import wspm_pkg::*;

  localparam logic [7:0] LEVEL_MAX = 8'(LEVEL_COUNT - 1);

  logic        screen_on, screen_on_next;
  logic        touch_pending, touch_pending_next;
  logic [31:0] last_activity, last_activity_next;
  logic        button_was_down, button_was_down_next;
  logic [31:0] press_start, press_start_next;
  logic        hold_reported, hold_reported_next;
  logic        wrist_previous, wrist_previous_next;
  logic [7:0]  duty_now, duty_now_next;

  logic [31:0] idle;
  logic [31:0] held;
  logic [7:0]  level_clamped;
  logic [2:0]  level_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_on       <= 1'b1;
      touch_pending   <= 1'b0;
      last_activity   <= '0;
      button_was_down <= 1'b0;
      press_start     <= '0;
      hold_reported   <= 1'b0;
      wrist_previous  <= 1'b0;
      duty_now        <= '0;
    end else if (go) begin
      screen_on       <= screen_on_next;
      touch_pending   <= touch_pending_next;
      last_activity   <= last_activity_next;
      button_was_down <= button_was_down_next;
      press_start     <= press_start_next;
      hold_reported   <= hold_reported_next;
      wrist_previous  <= wrist_previous_next;
      duty_now        <= duty_now_next;
    end
  end

  assign level_clamped = (item.level > LEVEL_MAX) ? LEVEL_MAX : item.level;
  assign level_idx     = level_clamped[2:0];
  assign held          = item.time_ms - press_start;

  always_comb begin
    screen_on_next       = screen_on;
    touch_pending_next   = touch_pending;
    last_activity_next   = last_activity;
    button_was_down_next = button_was_down;
    press_start_next     = press_start;
    hold_reported_next   = hold_reported;
    wrist_previous_next  = wrist_previous;
    duty_now_next        = duty_now;
    result               = '0;
    result.button_event  = EVT_NONE;
    idle                 = '0;

    unique case (item.mode)
      MODE_UPDATE: begin
        if (item.wrist_raised && !wrist_previous) begin
          if (!screen_on_next) begin
            screen_on_next     = 1'b1;
            touch_pending_next = 1'b0;
          end
          last_activity_next = item.time_ms;
        end
        wrist_previous_next = item.wrist_raised;
        if (item.button_down && !button_was_down) begin
          button_was_down_next = 1'b1;
          press_start_next     = item.time_ms;
          hold_reported_next   = 1'b0;
          if (!screen_on_next) begin
            screen_on_next     = 1'b1;
            touch_pending_next = 1'b0;
          end
          last_activity_next = item.time_ms;
        end else if (item.button_down && button_was_down) begin
          if (!hold_reported && held >= {16'd0, cfg.hold_time}) begin
            hold_reported_next  = 1'b1;
            result.button_event = EVT_HOLD;
          end
        end else if (!item.button_down && button_was_down) begin
          button_was_down_next = 1'b0;
          if (!hold_reported) result.button_event = EVT_SHORT;
        end
        idle = item.time_ms - last_activity_next;
        if (!cfg.always_on && screen_on_next) begin
          if (idle >= {8'd0, cfg.off_time}) begin
            screen_on_next      = 1'b0;
            duty_now_next       = '0;
            result.duty_written = 1'b1;
          end else if (idle >= {8'd0, cfg.dim_time}) begin
            duty_now_next       = cfg.dim_duty;
            result.duty_written = 1'b1;
          end
        end
      end
      MODE_ACTIVITY: begin
        last_activity_next = item.time_ms;
      end
      MODE_WAKE: begin
        if (!screen_on) begin
          screen_on_next     = 1'b1;
          touch_pending_next = item.by_touch;
        end
        last_activity_next = item.time_ms;
      end
      MODE_BRIGHTNESS: begin
        if (!screen_on) begin
          duty_now_next = '0;
        end else if (item.torch_on) begin
          duty_now_next = cfg.torch_duty;
        end else begin
          duty_now_next = cfg.level_duties[{level_idx, 3'b000} +: 8];
        end
        result.duty_written = 1'b1;
      end
      MODE_TAKE_TOUCH: begin
        if (touch_pending) begin
          touch_pending_next      = 1'b0;
          result.wake_touch_taken = 1'b1;
        end
      end
      MODE_POWER_OFF: begin
        duty_now_next        = '0;
        result.duty_written  = 1'b1;
        screen_on_next       = 1'b0;
        result.sleep_request = 1'b1;
      end
      default: ;
    endcase

    result.backlight_duty = duty_now_next;
    result.screen_is_on   = screen_on_next;
  end

`ifndef SYNTHESIS
  a_sleep_clears: assert property (@(posedge clk) disable iff (rst)
    go && item.mode == MODE_POWER_OFF |=> !screen_on && duty_now == 8'd0)
    else $error("Power off did not clear the screen and duty.");
  a_touch_only_taken: assert property (@(posedge clk) disable iff (rst)
    go && touch_pending && !touch_pending_next |->
      result.wake_touch_taken || item.mode == MODE_UPDATE || item.mode == MODE_WAKE)
    else $error("Pending wake touch lost without being taken.");
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(duty_now) && $stable(screen_on) && $stable(last_activity))
    else $error("Event state changed without an event.");
`endif

endmodule
